// ----- sv/wgm_pkg.sv -----
// Shared types and constants for the glob matcher.
`timescale 1ns / 1ps

package wgm_pkg;

    // Opcodes of an input item.
    localparam logic [1:0] OP_PAT_APPEND  = 2'd0;
    localparam logic [1:0] OP_SUBJ_APPEND = 2'd1;
    localparam logic [1:0] OP_EVALUATE    = 2'd2;

    // Wildcard characters.
    localparam logic [7:0] STAR_CHAR     = 8'd42;
    localparam logic [7:0] QUESTION_CHAR = 8'd63;

    // One input item.
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_value;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic matched;
        logic overflowed;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append_pat;  // store the item's character in the pattern
        logic append_subj; // store the item's character in the subject
        logic clear;       // empty both stores and drop the overflow flag
        logic start;       // zero the search pointers
        logic step;        // advance both pointers after a good compare
        logic take_star;   // remember a star: anchor at s, move p past it
        logic skip_adv;    // move p past one more star
        logic star_done;   // pattern anchor becomes the current p
        logic retry;       // backtrack: subject anchor plus one, p to anchor
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic s_in_range;  // subject pointer below subject length
        logic p_in_range;  // pattern pointer below pattern length
        logic pat_star;    // pattern character read is a star
        logic char_ok;     // pattern character accepts the subject character
        logic star_seen;   // a star was met in this search
        logic overflow;    // a store overflowed since the last evaluation
    } status_t;

endpackage

// ----- sv/wgm_datapath.sv -----
// Datapath of the glob matcher: character stores, lengths and search pointers.
`timescale 1ns / 1ps

module wgm_datapath
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_SUBJECT = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cmd_t     cmd,
    input  logic [7:0] char_value,
    output status_t  status
);

    localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
    localparam int SLEN_W = $clog2(MAX_SUBJECT + 1);
    localparam int PIDX_W = $clog2(MAX_PATTERN);
    localparam int SIDX_W = $clog2(MAX_SUBJECT);

    logic [7:0] pat_store_reg  [MAX_PATTERN];
    logic [7:0] subj_store_reg [MAX_SUBJECT];
    logic [7:0] pat_rdata_reg;
    logic [7:0] subj_rdata_reg;

    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [SLEN_W-1:0] slen_reg, slen_next;
    logic              overflow_reg, overflow_next;
    logic [PLEN_W-1:0] p_reg, p_next;
    logic [PLEN_W-1:0] ap_reg, ap_next;
    logic [SLEN_W-1:0] s_reg, s_next;
    logic [SLEN_W-1:0] as_reg, as_next;
    logic              star_reg, star_next;

    logic pat_full;
    logic subj_full;

    assign pat_full  = (plen_reg == PLEN_W'(MAX_PATTERN));
    assign subj_full = (slen_reg == SLEN_W'(MAX_SUBJECT));

    // Store writes happen only at append time; reads follow the pointers every cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.append_pat && !pat_full)
        begin
            pat_store_reg[plen_reg[PIDX_W-1:0]] <= char_value;
        end
        if (cmd.append_subj && !subj_full)
        begin
            subj_store_reg[slen_reg[SIDX_W-1:0]] <= char_value;
        end
        pat_rdata_reg  <= pat_store_reg[p_reg[PIDX_W-1:0]];
        subj_rdata_reg <= subj_store_reg[s_reg[SIDX_W-1:0]];
    end

    // Lengths and the overflow flag.
    always_comb
    begin
        plen_next     = plen_reg;
        slen_next     = slen_reg;
        overflow_next = overflow_reg;
        if (cmd.clear)
        begin
            plen_next     = '0;
            slen_next     = '0;
            overflow_next = 1'b0;
        end
        else if (cmd.append_pat)
        begin
            if (pat_full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                plen_next = plen_reg + PLEN_W'(1);
            end
        end
        else if (cmd.append_subj)
        begin
            if (subj_full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                slen_next = slen_reg + SLEN_W'(1);
            end
        end
    end

    // Search pointers, anchors and the star marker.
    always_comb
    begin
        p_next    = p_reg;
        ap_next   = ap_reg;
        s_next    = s_reg;
        as_next   = as_reg;
        star_next = star_reg;
        if (cmd.start)
        begin
            p_next    = '0;
            ap_next   = '0;
            s_next    = '0;
            as_next   = '0;
            star_next = 1'b0;
        end
        else if (cmd.step)
        begin
            p_next = p_reg + PLEN_W'(1);
            s_next = s_reg + SLEN_W'(1);
        end
        else if (cmd.take_star)
        begin
            star_next = 1'b1;
            as_next   = s_reg;
            p_next    = p_reg + PLEN_W'(1);
        end
        else if (cmd.skip_adv)
        begin
            p_next = p_reg + PLEN_W'(1);
        end
        else if (cmd.star_done)
        begin
            ap_next = p_reg;
        end
        else if (cmd.retry)
        begin
            as_next = as_reg + SLEN_W'(1);
            s_next  = as_reg + SLEN_W'(1);
            p_next  = ap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= '0;
            slen_reg     <= '0;
            overflow_reg <= 1'b0;
            p_reg        <= '0;
            ap_reg       <= '0;
            s_reg        <= '0;
            as_reg       <= '0;
            star_reg     <= 1'b0;
        end
        else
        begin
            plen_reg     <= plen_next;
            slen_reg     <= slen_next;
            overflow_reg <= overflow_next;
            p_reg        <= p_next;
            ap_reg       <= ap_next;
            s_reg        <= s_next;
            as_reg       <= as_next;
            star_reg     <= star_next;
        end
    end

    // Status back to the controller.
    always_comb
    begin
        status.s_in_range = (s_reg < slen_reg);
        status.p_in_range = (p_reg < plen_reg);
        status.pat_star   = (pat_rdata_reg == STAR_CHAR);
        status.char_ok    = (pat_rdata_reg == QUESTION_CHAR) ||
                            (pat_rdata_reg == subj_rdata_reg);
        status.star_seen  = star_reg;
        status.overflow   = overflow_reg;
    end

endmodule

// ----- sv/wgm_controller.sv -----
// Controller of the glob matcher: handshakes, search sequencing and the result register.
`timescale 1ns / 1ps

module wgm_controller
    import wgm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result,
    input  status_t   status,
    output cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE       = 5'b00001,
        ST_FETCH      = 5'b00010,
        ST_COMPARE    = 5'b00100,
        ST_SKIP_FETCH = 5'b01000,
        ST_SKIP_CMP   = 5'b10000
    } state_t;

    state_t    state_reg, state_next;
    logic      tail_reg, tail_next;         // star skip at the end of the subject
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic      item_xfer;

    assign item_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || result_ready);
    assign item_xfer    = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Search sequencer.
    always_comb
    begin
        state_next     = state_reg;
        tail_next      = tail_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    case (item.opcode)
                        OP_PAT_APPEND:  cmd.append_pat  = 1'b1;
                        OP_SUBJ_APPEND: cmd.append_subj = 1'b1;
                        OP_EVALUATE:
                        begin
                            if (status.overflow)
                            begin
                                cmd.clear          = 1'b1;
                                out_valid_next     = 1'b1;
                                out_next.matched    = 1'b0;
                                out_next.overflowed = 1'b1;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                state_next = ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_FETCH:
            begin
                if (!status.s_in_range)
                begin
                    tail_next  = 1'b1;
                    state_next = ST_SKIP_FETCH;
                end
                else if (!status.p_in_range)
                begin
                    if (status.star_seen)
                    begin
                        cmd.retry = 1'b1;
                    end
                    else
                    begin
                        cmd.clear           = 1'b1;
                        out_valid_next      = 1'b1;
                        out_next.matched    = 1'b0;
                        out_next.overflowed = 1'b0;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_COMPARE;
                end
            end

            ST_COMPARE:
            begin
                if (status.pat_star)
                begin
                    cmd.take_star = 1'b1;
                    tail_next     = 1'b0;
                    state_next    = ST_SKIP_FETCH;
                end
                else if (status.char_ok)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_FETCH;
                end
                else if (status.star_seen)
                begin
                    cmd.retry  = 1'b1;
                    state_next = ST_FETCH;
                end
                else
                begin
                    cmd.clear           = 1'b1;
                    out_valid_next      = 1'b1;
                    out_next.matched    = 1'b0;
                    out_next.overflowed = 1'b0;
                    state_next          = ST_IDLE;
                end
            end

            ST_SKIP_FETCH:
            begin
                // Only stars remain in the pattern: the rest of the subject matches.
                if (!status.p_in_range)
                begin
                    cmd.clear           = 1'b1;
                    out_valid_next      = 1'b1;
                    out_next.matched    = 1'b1;
                    out_next.overflowed = 1'b0;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SKIP_CMP;
                end
            end

            ST_SKIP_CMP:
            begin
                if (status.pat_star)
                begin
                    cmd.skip_adv = 1'b1;
                    state_next   = ST_SKIP_FETCH;
                end
                else if (tail_reg)
                begin
                    cmd.clear           = 1'b1;
                    out_valid_next      = 1'b1;
                    out_next.matched    = 1'b0;
                    out_next.overflowed = 1'b0;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    cmd.star_done = 1'b1;
                    state_next    = ST_FETCH;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    // A clean evaluate transfer starts a search on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && item.opcode == OP_EVALUATE && !status.overflow)
            |=> (state_reg == ST_FETCH))
    else $error("evaluate transfer did not start a search");

    // The result register is empty for the whole search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !out_valid_reg)
    else $error("search running while a result is pending");

    // Clearing the stores always drops the overflow flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> !status.overflow)
    else $error("overflow flag survived a clear");

    // An overflowed result never reports a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.overflowed) |-> !out_reg.matched)
    else $error("overflowed result reports a match");
`endif

endmodule

// ----- sv/wildcard_glob_matcher.sv -----
// Top level of the glob matcher: controller and datapath.
`timescale 1ns / 1ps

// Glob matcher with '?' and '*' wildcards. Append items (one per cycle) store a
// pattern or subject character; an evaluate item searches greedily, backtracking
// to the last star, and returns one result, then empties both stores. Appends
// past MAX_PATTERN or MAX_SUBJECT characters are dropped and the next result
// reports overflow with no match, in the cycle after the evaluate transfer. A clean
// search reads both stores through one registered read port each, so every
// compare step passes through a fetch state and then a compare state. Input
// stalls during the search and, for every kind of item, while a finished result
// waits to be taken.
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_SUBJECT = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    cmd_t    cmd;
    status_t status;

    wgm_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .status       (status),
        .cmd          (cmd)
    );

    wgm_datapath #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_SUBJECT (MAX_SUBJECT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .char_value (item.char_value),
        .status     (status)
    );

endmodule

// ----- tb/testbench.sv -----
// Testbench for the glob matcher: directed and random pattern/subject sets checked by a predictor.
`timescale 1ns / 1ps

module testbench;
    import wgm_pkg::*;

    localparam int MAX_PAT  = 32;
    localparam int MAX_SUBJ = 32;

    // Opcode 3 has no meaning; the matcher must drop it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    // Predictor state: the two stores, their lengths and the overflow flag.
    logic [7:0] pat_mem [0:MAX_PAT-1];
    logic [7:0] subj_mem [0:MAX_SUBJ-1];
    int         pat_len = 0;
    int         subj_len = 0;
    bit         store_overflow = 1'b0;

    // Verdicts predicted for evaluations that have been transferred.
    out_item_t  pending_verdicts [$];

    // Text of the next set to send.
    logic [7:0] pat_text [$];
    logic [7:0] subj_text [$];

    bit calm = 1'b0;
    bit noise_on = 1'b0;
    int stall_left = 0;
    int errors = 0;
    int accepted_items = 0;
    int append_count = 0;
    int eval_count = 0;
    int match_count = 0;
    int overflow_count = 0;
    int ignored_count = 0;

    wildcard_glob_matcher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Glob match with backtracking to the latest star.
    function automatic bit glob_hit();
        int s;
        int p;
        int star_at;
        int resume_s;
        s = 0;
        p = 0;
        star_at = -1;
        resume_s = 0;
        while (s < subj_len)
        begin
            if (p < pat_len && pat_mem[p] == STAR_CHAR)
            begin
                star_at = p;
                resume_s = s;
                p++;
            end
            else if (p < pat_len &&
                     (pat_mem[p] == QUESTION_CHAR || pat_mem[p] == subj_mem[s]))
            begin
                s++;
                p++;
            end
            else if (star_at >= 0)
            begin
                resume_s++;
                s = resume_s;
                p = star_at + 1;
            end
            else
            begin
                return 1'b0;
            end
        end
        while (p < pat_len && pat_mem[p] == STAR_CHAR)
            p++;
        return p == pat_len;
    endfunction

    // Update the predicted state for one transferred item.
    function automatic void predict_verdict(input in_item_t it);
        out_item_t v;
        case (it.opcode)
            OP_PAT_APPEND:
            begin
                append_count++;
                if (pat_len < MAX_PAT)
                begin
                    pat_mem[pat_len] = it.char_value;
                    pat_len++;
                end
                else
                    store_overflow = 1'b1;
            end
            OP_SUBJ_APPEND:
            begin
                append_count++;
                if (subj_len < MAX_SUBJ)
                begin
                    subj_mem[subj_len] = it.char_value;
                    subj_len++;
                end
                else
                    store_overflow = 1'b1;
            end
            OP_EVALUATE:
            begin
                v.overflowed = store_overflow;
                v.matched = store_overflow ? 1'b0 : glob_hit();
                pending_verdicts = {pending_verdicts, v};
                eval_count++;
                if (v.matched)
                    match_count++;
                if (v.overflowed)
                    overflow_count++;
                pat_len = 0;
                subj_len = 0;
                store_overflow = 1'b0;
            end
            default:
                ignored_count++;
        endcase
    endfunction

    // Drive one item at the falling edge and hold it until its transfer.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_verdict(it);
        if (it.opcode != OP_UNUSED)
            accepted_items++;
    endtask

    // Send the queued pattern and subject, interleaved at random, then evaluate.
    task automatic send_set();
        int pi;
        int si;
        in_item_t it;
        pi = 0;
        si = 0;
        while (pi < pat_text.size() || si < subj_text.size())
        begin
            if (si >= subj_text.size() ||
                (pi < pat_text.size() && $urandom_range(0, 1) == 0))
            begin
                it.opcode = OP_PAT_APPEND;
                it.char_value = pat_text[pi];
                pi++;
            end
            else
            begin
                it.opcode = OP_SUBJ_APPEND;
                it.char_value = subj_text[si];
                si++;
            end
            send_item(it);
            if (noise_on && $urandom_range(0, 39) == 0)
            begin
                it.opcode = OP_UNUSED;
                it.char_value = 8'($urandom_range(0, 255));
                send_item(it);
            end
        end
        it.opcode = OP_EVALUATE;
        it.char_value = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic load_text(input string p, input string s);
        int k;
        pat_text.delete();
        subj_text.delete();
        for (k = 0; k < p.len(); k++)
            pat_text = {pat_text, p[k]};
        for (k = 0; k < s.len(); k++)
            subj_text = {subj_text, s[k]};
    endtask

    // Mostly a small alphabet so that literals line up; sometimes any byte.
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 3) != 0)
            return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_pat_char();
        case ($urandom_range(0, 5))
            0: return STAR_CHAR;
            1: return QUESTION_CHAR;
            default: return pick_char();
        endcase
    endfunction

    // Build a subject and a pattern derived from it, sometimes broken on purpose.
    task automatic build_glob_pair();
        int n;
        int k;
        int r;
        int idx;
        pat_text.delete();
        subj_text.delete();
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(0, MAX_SUBJ);
        else
            n = $urandom_range(0, 6);
        for (k = 0; k < n; k++)
            subj_text = {subj_text, pick_char()};
        if ($urandom_range(0, 9) >= 8)
        begin
            // Unrelated pattern with wildcards mixed in.
            n = $urandom_range(0, 8);
            for (k = 0; k < n; k++)
                pat_text = {pat_text, pick_pat_char()};
        end
        else
        begin
            k = 0;
            while (k < subj_text.size())
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                begin
                    pat_text = {pat_text, subj_text[k]};
                    k++;
                end
                else if (r < 7)
                begin
                    pat_text = {pat_text, QUESTION_CHAR};
                    k++;
                end
                else if (r < 9)
                begin
                    pat_text = {pat_text, STAR_CHAR};
                    k += $urandom_range(0, 3);
                end
                else
                    pat_text = {pat_text, STAR_CHAR};
            end
            if ($urandom_range(0, 5) == 0)
                pat_text = {pat_text, STAR_CHAR};
            // Break some of the well-formed pairs.
            if ($urandom_range(0, 3) == 0)
            begin
                r = $urandom_range(0, 2);
                if (r == 0 && pat_text.size() > 0)
                begin
                    idx = $urandom_range(0, pat_text.size() - 1);
                    pat_text[idx] = pick_char();
                end
                else if (r == 1 && pat_text.size() > 0)
                    pat_text.delete($urandom_range(0, pat_text.size() - 1));
                else
                    pat_text = {pat_text, pick_pat_char()};
            end
        end
    endtask

    task automatic test_empty_strings();
        load_text("", "");
        send_set();
        load_text("**", "");
        send_set();
        load_text("", "a");
        send_set();
    endtask

    task automatic test_wildcards();
        load_text("a?c", "abc");
        send_set();
        load_text("*?b", "ab");
        send_set();
        load_text("a?", "b");
        send_set();
    endtask

    // Byte zero and byte 255 are ordinary characters.
    task automatic test_byte_extremes();
        pat_text.delete();
        subj_text.delete();
        pat_text = {pat_text, 8'h00};
        pat_text = {pat_text, 8'hFF};
        subj_text = {subj_text, 8'h00};
        subj_text = {subj_text, 8'hFF};
        send_set();
    endtask

    // An unused opcode in the middle of a set must change nothing.
    task automatic test_unused_opcode();
        in_item_t it;
        it.opcode = OP_PAT_APPEND;
        it.char_value = 8'h61;
        send_item(it);
        it.opcode = OP_UNUSED;
        it.char_value = 8'hFF;
        send_item(it);
        load_text("", "a");
        send_set();
    endtask

    task automatic test_random_globs(input int stop_at);
        noise_on = 1'b1;
        while (accepted_items < stop_at)
        begin
            build_glob_pair();
            send_set();
        end
    endtask

    // Full stores, and one to four characters past either limit.
    task automatic test_store_overflow();
        int k;
        int n;
        int j;
        for (k = 0; k < 6; k++)
        begin
            pat_text.delete();
            subj_text.delete();
            case (k % 3)
                0:
                begin
                    for (j = 0; j < MAX_SUBJ; j++)
                        subj_text = {subj_text, 8'h61 + 8'($urandom_range(0, 1))};
                    pat_text = {pat_text, STAR_CHAR};
                    for (j = 1; j < MAX_PAT; j++)
                        pat_text = {pat_text, ($urandom_range(0, 3) == 0 ?
                                               QUESTION_CHAR : subj_text[j])};
                end
                1:
                begin
                    n = MAX_PAT + $urandom_range(1, 4);
                    for (j = 0; j < n; j++)
                        pat_text = {pat_text, pick_pat_char()};
                    for (j = 0; j < 4; j++)
                        subj_text = {subj_text, pick_char()};
                end
                default:
                begin
                    n = MAX_SUBJ + $urandom_range(1, 4);
                    for (j = 0; j < n; j++)
                        subj_text = {subj_text, pick_char()};
                    pat_text = {pat_text, STAR_CHAR};
                end
            endcase
            send_set();
        end
    endtask

    task automatic test_quiet_tail(input int count);
        int stop_at;
        calm = 1'b1;
        stop_at = accepted_items + count;
        test_random_globs(stop_at);
    endtask

    // Result side: ready drops in random bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready = 1'b0;
            stall_left--;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            result_ready = 1'b0;
            stall_left = $urandom_range(0, 8);
        end
        else
            result_ready = 1'b1;
    end

    // Compare each result transfer with the oldest predicted verdict.
    always @(posedge clk)
    begin : check_verdict
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result matched=%0b overflowed=%0b",
                         $time, result.matched, result.overflowed);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.matched !== want.matched)
                begin
                    errors++;
                    $display("%0t: matched expected %0b actual %0b",
                             $time, want.matched, result.matched);
                end
                if (result.overflowed !== want.overflowed)
                begin
                    errors++;
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, want.overflowed, result.overflowed);
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_empty_strings();
        test_wildcards();
        test_byte_extremes();
        test_unused_opcode();
        test_random_globs(600);
        test_store_overflow();
        test_quiet_tail(150);

        @(negedge clk);
        item_valid = 1'b0;
        while (pending_verdicts.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d appends and %0d evaluations, plus %0d unused opcodes.",
                 append_count, eval_count, ignored_count);
        $display("Evaluations gave %0d matches and %0d overflow reports.",
                 match_count, overflow_count);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4000000;
        $display("Timed out with %0d verdicts outstanding.", pending_verdicts.size());
        $display("FAIL");
        $finish;
    end

endmodule
